### hw/rtl/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation block.
package bpc_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned RawW  = 19;
    localparam int unsigned CfgIdxW = 3;

    // Register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_B1_B2   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MC_MD   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_OSS     = 3'd5;

    // Item kinds
    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    localparam logic [DataW-1:0] B6_OFFSET   = 32'd4000;
    localparam logic [DataW-1:0] B4_OFFSET   = 32'd32768;
    localparam logic [DataW-1:0] B7_SCALE    = 32'd50000;
    localparam logic [DataW-1:0] CORR_SQ     = 32'd3038;
    localparam logic [DataW-1:0] CORR_LIN    = 32'hFFFF_E343; // -7357
    localparam logic [DataW-1:0] CORR_OFFSET = 32'd3791;
    localparam logic [DataW-1:0] TEMP_ROUND  = 32'd8;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_MUL,
        S_T_DEN,
        S_T_DIV,
        S_P_B6,
        S_P_SQ,
        S_P_X1,
        S_P_B3,
        S_P_X1B,
        S_P_X3,
        S_P_B4,
        S_P_B7,
        S_P_DIV,
        S_P_C1,
        S_P_C2,
        S_P_C3
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DataW-1:0] dividend;
        logic [DataW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DataW-1:0] quotient;
    } div_rsp_t;

    // Arithmetic shift right of a 32-bit word
    function automatic logic [DataW-1:0] asr(input logic [DataW-1:0] v,
                                             input logic [4:0] n);
        asr = DataW'($signed(v) >>> n);
    endfunction

    function automatic logic [DataW-1:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

endpackage

### hw/rtl/bpc_mul.sv
// Shared 32x32 multiplier keeping the low word, result registered.
module bpc_mul (
    input  logic                        aclk,
    input  logic [bpc_pkg::DataW-1:0]   op_a,
    input  logic [bpc_pkg::DataW-1:0]   op_b,
    output logic [bpc_pkg::DataW-1:0]   prod
);

    logic [bpc_pkg::DataW-1:0] prod_reg;
    logic [bpc_pkg::DataW-1:0] prod_next;

    // Wrap the product at 32 bits
    always_comb begin
        prod_next = bpc_pkg::DataW'(op_a * op_b);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

### hw/rtl/bpc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module bpc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpc_pkg::div_req_t   req,
    output bpc_pkg::div_rsp_t   rsp
);

    localparam int unsigned W    = bpc_pkg::DataW;
    localparam int unsigned CntW = $clog2(W);

    logic [W-1:0]    rem_reg,  rem_next;
    logic [W-1:0]    quo_reg,  quo_next;
    logic [W-1:0]    dvs_reg,  dvs_next;
    logic [CntW-1:0] cnt_reg,  cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [W:0]      rem_sh;
    logic [W:0]      rem_sub;

    // Shift in one dividend bit and try the subtraction
    always_comb begin
        rem_sh    = {rem_reg, quo_reg[W-1]};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!rem_sub[W]) begin
                rem_next = rem_sub[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hw/rtl/barometric_pressure_compensation.sv
// Top level: sequencer and datapath for sensor temperature and pressure compensation.
//
// channel  | direction | handshake              | contents
// s_       | in        | s_tvalid / s_tready    | raw sample word, kind in tuser
// m_       | out       | m_tvalid / m_tready    | value word, kind and error flag in tuser
// cfg_     | in        | cfg_valid / cfg_ready  | calibration and oversampling registers
//
// A temperature word uses the shared multiplier and then the bit-serial divider; a
// pressure word runs a chain of multiplier steps around one divide. A zero divisor
// ends the item early, with the error flag set and a zero value.
// One word is in flight at a time; s_tready is low from acceptance until the
// result word has been taken. aresetn is synchronous and active low.
module barometric_pressure_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [18:0] raw_sample, [23:19] zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [1:0]  m_tuser,   // [0] kind, [1] div_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned W = bpc_pkg::DataW;

    bpc_pkg::state_t state_reg, state_next;

    logic [W-1:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]   oss_reg;
    logic [W-1:0] tt_reg;

    logic [bpc_pkg::RawW-1:0] raw_reg;
    logic [W-1:0] x1_reg, b6_reg, sq_reg, acc_reg, b3_reg, b4_reg, p_reg;
    logic         neg_reg, post_shift_reg;

    logic         out_valid_reg;
    logic         out_kind_reg, out_err_reg;
    logic [W-1:0] out_value_reg;

    logic [W-1:0] mul_a, mul_b, prod;
    bpc_pkg::div_req_t div_req;
    bpc_pkg::div_rsp_t div_rsp;

    // Calibration fields
    logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, raw32;
    assign ac1 = bpc_pkg::sext16(ac12_reg[31:16]);
    assign ac2 = bpc_pkg::sext16(ac12_reg[15:0]);
    assign ac3 = bpc_pkg::sext16(ac34_reg[31:16]);
    assign ac4 = {16'd0, ac34_reg[15:0]};
    assign ac5 = {16'd0, ac56_reg[31:16]};
    assign ac6 = {16'd0, ac56_reg[15:0]};
    assign b1  = bpc_pkg::sext16(b12_reg[31:16]);
    assign b2  = bpc_pkg::sext16(b12_reg[15:0]);
    assign mc  = bpc_pkg::sext16(mcmd_reg[31:16]);
    assign md  = bpc_pkg::sext16(mcmd_reg[15:0]);
    assign raw32 = {{(W - bpc_pkg::RawW){1'b0}}, raw_reg};

    // Intermediate terms, many taken straight from the multiplier
    logic [W-1:0] t_x1, t_den, t_num, q_signed, b5, b6_now, sq_now;
    logic [W-1:0] x3_b3, b3_now, x3_b4, b4_now, p_now, p_sh8, p_final;
    assign t_x1     = bpc_pkg::asr(prod, 5'd15);
    assign t_den    = t_x1 + md;
    assign t_num    = mc << 11;
    assign q_signed = neg_reg ? (W'(0) - div_rsp.quotient) : div_rsp.quotient;
    assign b5       = x1_reg + q_signed;
    assign b6_now   = tt_reg - bpc_pkg::B6_OFFSET;
    assign sq_now   = bpc_pkg::asr(prod, 5'd12);
    assign x3_b3    = acc_reg + bpc_pkg::asr(prod, 5'd11);
    assign b3_now   = bpc_pkg::asr((((ac1 << 2) + x3_b3) << oss_reg) + W'(2), 5'd2);
    assign x3_b4    = bpc_pkg::asr(acc_reg + bpc_pkg::asr(prod, 5'd16) + W'(2), 5'd2);
    assign b4_now   = prod >> 15;
    assign p_now    = post_shift_reg ? (div_rsp.quotient << 1) : div_rsp.quotient;
    assign p_sh8    = bpc_pkg::asr(p_now, 5'd8);
    assign p_final  = p_reg + bpc_pkg::asr(acc_reg + bpc_pkg::asr(prod, 5'd16)
                      + bpc_pkg::CORR_OFFSET, 5'd4);

    bpc_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    bpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready  = (state_reg == bpc_pkg::S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bpc_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = (s_tuser == bpc_pkg::KIND_PRESS) ? bpc_pkg::S_P_B6
                                                                  : bpc_pkg::S_T_MUL;
                end
            end
            bpc_pkg::S_T_MUL: state_next = bpc_pkg::S_T_DEN;
            bpc_pkg::S_T_DEN: begin
                state_next = (t_den == '0) ? bpc_pkg::S_IDLE : bpc_pkg::S_T_DIV;
            end
            bpc_pkg::S_T_DIV: if (div_rsp.done) begin
                state_next = bpc_pkg::S_IDLE;
            end
            bpc_pkg::S_P_B6:  state_next = bpc_pkg::S_P_SQ;
            bpc_pkg::S_P_SQ:  state_next = bpc_pkg::S_P_X1;
            bpc_pkg::S_P_X1:  state_next = bpc_pkg::S_P_B3;
            bpc_pkg::S_P_B3:  state_next = bpc_pkg::S_P_X1B;
            bpc_pkg::S_P_X1B: state_next = bpc_pkg::S_P_X3;
            bpc_pkg::S_P_X3:  state_next = bpc_pkg::S_P_B4;
            bpc_pkg::S_P_B4:  state_next = bpc_pkg::S_P_B7;
            bpc_pkg::S_P_B7: begin
                state_next = (b4_reg == '0) ? bpc_pkg::S_IDLE : bpc_pkg::S_P_DIV;
            end
            bpc_pkg::S_P_DIV: if (div_rsp.done) begin
                state_next = bpc_pkg::S_P_C1;
            end
            bpc_pkg::S_P_C1:  state_next = bpc_pkg::S_P_C2;
            bpc_pkg::S_P_C2:  state_next = bpc_pkg::S_P_C3;
            bpc_pkg::S_P_C3:  state_next = bpc_pkg::S_IDLE;
            default:          state_next = bpc_pkg::S_IDLE;
        endcase
    end

    // Steer the shared multiplier and start the divider
    always_comb begin
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            bpc_pkg::S_T_MUL: begin
                mul_a = raw32 - ac6;
                mul_b = ac5;
            end
            bpc_pkg::S_T_DEN: begin
                div_req.start    = (t_den != '0);
                div_req.dividend = t_num[W-1] ? (W'(0) - t_num) : t_num;
                div_req.divisor  = t_den[W-1] ? (W'(0) - t_den) : t_den;
            end
            bpc_pkg::S_P_B6: begin
                mul_a = b6_now;
                mul_b = b6_now;
            end
            bpc_pkg::S_P_SQ: begin
                mul_a = b2;
                mul_b = sq_now;
            end
            bpc_pkg::S_P_X1: begin
                mul_a = ac2;
                mul_b = b6_reg;
            end
            bpc_pkg::S_P_B3: begin
                mul_a = ac3;
                mul_b = b6_reg;
            end
            bpc_pkg::S_P_X1B: begin
                mul_a = b1;
                mul_b = sq_reg;
            end
            bpc_pkg::S_P_X3: begin
                mul_a = ac4;
                mul_b = x3_b4 + bpc_pkg::B4_OFFSET;
            end
            bpc_pkg::S_P_B4: begin
                mul_a = raw32 - b3_reg;
                mul_b = bpc_pkg::B7_SCALE >> oss_reg;
            end
            bpc_pkg::S_P_B7: begin
                div_req.start    = (b4_reg != '0);
                div_req.dividend = prod[W-1] ? prod : (prod << 1);
                div_req.divisor  = b4_reg;
            end
            bpc_pkg::S_P_DIV: begin
                mul_a = p_sh8;
                mul_b = p_sh8;
            end
            bpc_pkg::S_P_C1: begin
                mul_a = prod;
                mul_b = bpc_pkg::CORR_SQ;
            end
            bpc_pkg::S_P_C2: begin
                mul_a = bpc_pkg::CORR_LIN;
                mul_b = p_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer state, configuration registers and result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bpc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            ac12_reg      <= '0;
            ac34_reg      <= '0;
            ac56_reg      <= '0;
            b12_reg       <= '0;
            mcmd_reg      <= '0;
            oss_reg       <= 2'd3;
            tt_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    bpc_pkg::REG_AC1_AC2: ac12_reg <= cfg_data;
                    bpc_pkg::REG_AC3_AC4: ac34_reg <= cfg_data;
                    bpc_pkg::REG_AC5_AC6: ac56_reg <= cfg_data;
                    bpc_pkg::REG_B1_B2:   b12_reg  <= cfg_data;
                    bpc_pkg::REG_MC_MD:   mcmd_reg <= cfg_data;
                    bpc_pkg::REG_OSS:     oss_reg  <= cfg_data[1:0];
                    default: ;
                endcase
            end
            // Finish an item
            unique case (state_reg)
                bpc_pkg::S_T_DEN: if (t_den == '0) begin
                    out_valid_reg <= 1'b1;
                end
                bpc_pkg::S_T_DIV: if (div_rsp.done) begin
                    out_valid_reg <= 1'b1;
                    tt_reg        <= b5;
                end
                bpc_pkg::S_P_B7: if (b4_reg == '0) begin
                    out_valid_reg <= 1'b1;
                end
                bpc_pkg::S_P_C3: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            bpc_pkg::S_IDLE: begin
                raw_reg <= s_tdata[bpc_pkg::RawW-1:0];
            end
            bpc_pkg::S_T_DEN: begin
                x1_reg        <= t_x1;
                neg_reg       <= t_num[W-1] ^ t_den[W-1];
                out_kind_reg  <= bpc_pkg::KIND_TEMP;
                out_err_reg   <= 1'b1;
                out_value_reg <= '0;
            end
            bpc_pkg::S_T_DIV: begin
                out_err_reg   <= 1'b0;
                out_value_reg <= bpc_pkg::asr(b5 + bpc_pkg::TEMP_ROUND, 5'd4);
            end
            bpc_pkg::S_P_B6:  b6_reg  <= b6_now;
            bpc_pkg::S_P_SQ:  sq_reg  <= sq_now;
            bpc_pkg::S_P_X1:  acc_reg <= bpc_pkg::asr(prod, 5'd11);
            bpc_pkg::S_P_B3:  b3_reg  <= b3_now;
            bpc_pkg::S_P_X1B: acc_reg <= bpc_pkg::asr(prod, 5'd13);
            bpc_pkg::S_P_B4:  b4_reg  <= b4_now;
            bpc_pkg::S_P_B7: begin
                post_shift_reg <= prod[W-1];
                out_kind_reg   <= bpc_pkg::KIND_PRESS;
                out_err_reg    <= (b4_reg == '0);
                out_value_reg  <= '0;
            end
            bpc_pkg::S_P_DIV: p_reg   <= p_now;
            bpc_pkg::S_P_C2:  acc_reg <= bpc_pkg::asr(prod, 5'd16);
            bpc_pkg::S_P_C3:  out_value_reg <= p_final;
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_err_reg, out_kind_reg};

    // Checks
    a_no_accept_while_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result word waits");

    a_div_idle_outside_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> (state_reg == bpc_pkg::S_T_DIV || state_reg == bpc_pkg::S_P_DIV))
        else $error("divider busy outside a divide wait state");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != bpc_pkg::S_IDLE))
        else $error("sequencer stayed idle after accepting a word");

    a_result_kind_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) && (m_tuser[0] == bpc_pkg::KIND_TEMP) |->
            ($past(state_reg) == bpc_pkg::S_T_DEN || $past(state_reg) == bpc_pkg::S_T_DIV))
        else $error("temperature result raised from a pressure state");

endmodule
